// File: rtl/core/mse_pkg.sv
package mse_pkg;

  // element word width
  localparam int unsigned DATA_W = 32;

  // default buffer capacity
  localparam int unsigned MAX_ELEMENTS_DEF = 64;

  // sequencer states
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PASS_START,
    ST_RUN_START,
    ST_MERGE_RD,
    ST_MERGE_WR,
    ST_OUT_RD,
    ST_OUT_LD
  } state_e;

  // memory control from the sequencer to the two banks
  typedef struct packed {
    logic we0;
    logic we1;
    logic rd_sel;
  } mem_ctl_t;

endpackage

// File: rtl/core/mse_if.sv
interface mse_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [mse_pkg::DATA_W-1:0]   value;
  logic                                last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface mse_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [mse_pkg::DATA_W-1:0]   sorted_value;
  logic                                last_out;

  modport source (output valid, output sorted_value, output last_out, input ready);
  modport sink   (input valid, input sorted_value, input last_out, output ready);
endinterface

// File: rtl/core/mse_mem.sv
module mse_mem #(
  parameter int unsigned DEPTH = mse_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                              clk_i,
  input  logic                              we_i,
  input  logic [$clog2(DEPTH)-1:0]          waddr_i,
  input  logic signed [mse_pkg::DATA_W-1:0] wdata_i,
  input  logic [$clog2(DEPTH)-1:0]          raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0]          raddr_b_i,
  output logic signed [mse_pkg::DATA_W-1:0] rdata_a_o,
  output logic signed [mse_pkg::DATA_W-1:0] rdata_b_o
);

  logic signed [mse_pkg::DATA_W-1:0] mem [DEPTH];

  // one write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // two registered read ports
  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

// File: rtl/core/mse_sorter.sv
module mse_sorter #(
  parameter int unsigned MAX_ELEMENTS = mse_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  mse_in_if.sink                            in_i,
  mse_out_if.source                         out_o,
  output mse_pkg::mem_ctl_t                 ctl_o,
  output logic [$clog2(MAX_ELEMENTS)-1:0]   waddr_o,
  output logic signed [mse_pkg::DATA_W-1:0] wdata_o,
  output logic [$clog2(MAX_ELEMENTS)-1:0]   raddr_a_o,
  output logic [$clog2(MAX_ELEMENTS)-1:0]   raddr_b_o,
  input  logic signed [mse_pkg::DATA_W-1:0] rdata_a_i,
  input  logic signed [mse_pkg::DATA_W-1:0] rdata_b_i
);

  localparam int unsigned AW = $clog2(MAX_ELEMENTS);
  localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned WW = CW + 1;
  localparam int unsigned SW = CW + 2;

  mse_pkg::state_e state_q, state_d;

  logic [CW-1:0] count_q, count_d;
  logic [WW-1:0] width_q, width_d;
  logic [CW-1:0] lo_q, lo_d;
  logic [CW-1:0] mid_q, mid_d;
  logic [CW-1:0] hi_q, hi_d;
  logic [CW-1:0] i_q, i_d;
  logic [CW-1:0] j_q, j_d;
  logic [CW-1:0] k_q, k_d;
  logic          sel_q, sel_d;

  logic                              out_valid_q;
  logic signed [mse_pkg::DATA_W-1:0] out_value_q;
  logic                              out_last_q;

  logic          in_fire;
  logic          has_room;
  logic          out_free;
  logic          pass_done;
  logic          run_done;
  logic [SW-1:0] lo_w;
  logic [SW-1:0] lo_2w;
  logic [CW-1:0] mid_sat;
  logic [CW-1:0] hi_sat;
  logic          i_left;
  logic          j_left;
  logic          take_b;
  logic [CW-1:0] k_inc;
  logic          run_end;
  logic          out_end;

  // status terms
  assign in_fire   = in_i.valid && in_i.ready;
  assign has_room  = count_q < CW'(MAX_ELEMENTS);
  assign out_free  = !out_valid_q || out_o.ready;
  assign pass_done = width_q >= WW'(count_q);
  assign run_done  = lo_q >= count_q;
  assign lo_w      = SW'(lo_q) + SW'(width_q);
  assign lo_2w     = lo_w + SW'(width_q);
  assign mid_sat   = (lo_w > SW'(count_q)) ? count_q : lo_w[CW-1:0];
  assign hi_sat    = (lo_2w > SW'(count_q)) ? count_q : lo_2w[CW-1:0];
  assign i_left    = i_q < mid_q;
  assign j_left    = j_q < hi_q;
  // ties go to the left run
  assign take_b    = !i_left || (j_left && (rdata_b_i < rdata_a_i));
  assign k_inc     = k_q + CW'(1);
  assign run_end   = k_inc == hi_q;
  assign out_end   = k_inc == count_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mse_pkg::ST_LOAD: begin
        if (in_fire && in_i.last) state_d = mse_pkg::ST_PASS_START;
      end
      mse_pkg::ST_PASS_START: begin
        state_d = pass_done ? mse_pkg::ST_OUT_RD : mse_pkg::ST_RUN_START;
      end
      mse_pkg::ST_RUN_START: begin
        state_d = run_done ? mse_pkg::ST_PASS_START : mse_pkg::ST_MERGE_RD;
      end
      mse_pkg::ST_MERGE_RD: begin
        state_d = mse_pkg::ST_MERGE_WR;
      end
      mse_pkg::ST_MERGE_WR: begin
        state_d = run_end ? mse_pkg::ST_RUN_START : mse_pkg::ST_MERGE_RD;
      end
      mse_pkg::ST_OUT_RD: begin
        if (out_free) state_d = mse_pkg::ST_OUT_LD;
      end
      mse_pkg::ST_OUT_LD: begin
        state_d = out_end ? mse_pkg::ST_LOAD : mse_pkg::ST_OUT_RD;
      end
      default: state_d = mse_pkg::ST_LOAD;
    endcase
  end

  // handshake and memory port outputs
  always_comb begin
    in_i.ready   = state_q == mse_pkg::ST_LOAD;
    ctl_o.we0    = ((state_q == mse_pkg::ST_LOAD) && in_fire && has_room) ||
                   ((state_q == mse_pkg::ST_MERGE_WR) && sel_q);
    ctl_o.we1    = (state_q == mse_pkg::ST_MERGE_WR) && !sel_q;
    ctl_o.rd_sel = sel_q;
    waddr_o      = (state_q == mse_pkg::ST_LOAD) ? count_q[AW-1:0] : k_q[AW-1:0];
    wdata_o      = (state_q == mse_pkg::ST_LOAD) ? in_i.value :
                   (take_b ? rdata_b_i : rdata_a_i);
    raddr_a_o    = (state_q == mse_pkg::ST_OUT_RD) ? k_q[AW-1:0] : i_q[AW-1:0];
    raddr_b_o    = j_q[AW-1:0];
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.sorted_value = out_value_q;
  assign out_o.last_out     = out_last_q;

  // run pointers and counters
  always_comb begin
    count_d = count_q;
    width_d = width_q;
    lo_d    = lo_q;
    mid_d   = mid_q;
    hi_d    = hi_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    sel_d   = sel_q;
    case (state_q)
      mse_pkg::ST_LOAD: begin
        if (in_fire) begin
          if (has_room) count_d = count_q + CW'(1);
          if (in_i.last) begin
            width_d = WW'(1);
            sel_d   = 1'b0;
          end
        end
      end
      mse_pkg::ST_PASS_START: begin
        lo_d = '0;
        if (pass_done) k_d = '0;
      end
      mse_pkg::ST_RUN_START: begin
        if (run_done) begin
          sel_d   = !sel_q;
          width_d = width_q << 1;
        end else begin
          mid_d = mid_sat;
          hi_d  = hi_sat;
          i_d   = lo_q;
          j_d   = mid_sat;
          k_d   = lo_q;
        end
      end
      mse_pkg::ST_MERGE_WR: begin
        k_d = k_inc;
        if (take_b) j_d = j_q + CW'(1);
        else        i_d = i_q + CW'(1);
        if (run_end) lo_d = hi_q;
      end
      mse_pkg::ST_OUT_LD: begin
        k_d = k_inc;
        if (out_end) count_d = '0;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mse_pkg::ST_LOAD;
      count_q     <= '0;
      sel_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      sel_q   <= sel_d;
      if (state_q == mse_pkg::ST_OUT_LD) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // pointer and output payload registers
  always_ff @(posedge clk_i) begin
    width_q <= width_d;
    lo_q    <= lo_d;
    mid_q   <= mid_d;
    hi_q    <= hi_d;
    i_q     <= i_d;
    j_q     <= j_d;
    k_q     <= k_d;
    if (state_q == mse_pkg::ST_OUT_LD) begin
      out_value_q <= rdata_a_i;
      out_last_q  <= out_end;
    end
  end

endmodule

// File: rtl/core/merge_sort_engine.sv
// channel  dir  modport  payload                 beat taken when
// in_i     in   sink     value[31:0], last       valid && ready
// out_o    out  source   sorted_value[31:0],     valid && ready
//                        last_out
//
// ready is high only while loading, and low after the closing beat until
// the last sorted beat has been loaded into the output register.
// sorting takes ceil(log2 n) passes over the set: every merged element passes
// through a read state and then a write state on the memory banks.
// draining reads each element from a bank, then loads it into the output register.
// reset is asynchronous and active low; the banks need no clearing.
// a stalled output holds the drain; the final beat can wait while a new set loads.
module merge_sort_engine #(
  parameter int unsigned MAX_ELEMENTS = mse_pkg::MAX_ELEMENTS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mse_in_if.sink     in_i,
  mse_out_if.source  out_o
);

  localparam int unsigned AW = $clog2(MAX_ELEMENTS);

  mse_pkg::mem_ctl_t                 ctl;
  logic [AW-1:0]                     waddr;
  logic signed [mse_pkg::DATA_W-1:0] wdata;
  logic [AW-1:0]                     raddr_a;
  logic [AW-1:0]                     raddr_b;
  logic signed [mse_pkg::DATA_W-1:0] rd0_a, rd0_b;
  logic signed [mse_pkg::DATA_W-1:0] rd1_a, rd1_b;
  logic signed [mse_pkg::DATA_W-1:0] rdata_a, rdata_b;

  // sequencer
  mse_sorter #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_sorter (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .out_o     (out_o),
    .ctl_o     (ctl),
    .waddr_o   (waddr),
    .wdata_o   (wdata),
    .raddr_a_o (raddr_a),
    .raddr_b_o (raddr_b),
    .rdata_a_i (rdata_a),
    .rdata_b_i (rdata_b)
  );

  // element bank, loaded from the input
  mse_mem #(
    .DEPTH (MAX_ELEMENTS)
  ) u_bank0 (
    .clk_i     (clk_i),
    .we_i      (ctl.we0),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rd0_a),
    .rdata_b_o (rd0_b)
  );

  // scratch bank
  mse_mem #(
    .DEPTH (MAX_ELEMENTS)
  ) u_bank1 (
    .clk_i     (clk_i),
    .we_i      (ctl.we1),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rd1_a),
    .rdata_b_o (rd1_b)
  );

  // source bank select for the merge and the drain
  assign rdata_a = ctl.rd_sel ? rd1_a : rd0_a;
  assign rdata_b = ctl.rd_sel ? rd1_b : rd0_b;

  // the two banks are never written in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl.we0 && ctl.we1))
    else $error("both banks written in one cycle");

  // a closing beat stops the input while the set is sorted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready && in_i.last |=> !in_i.ready)
    else $error("input accepted right after a closing beat");

  // scratch writes happen only during a merge pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.we1 |-> !in_i.ready)
    else $error("scratch bank written while loading");

  // the merge reads the bank it did not just write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.we0 && !in_i.ready |-> ctl.rd_sel)
    else $error("merge writing into its own source bank");

endmodule

// File: verif/merge_sort_engine_tb.sv
module merge_sort_engine_tb;

  localparam int unsigned CAPACITY = mse_pkg::MAX_ELEMENTS_DEF;
  localparam int unsigned RANDOM_BEATS = 230;
  localparam int unsigned DRAIN_CYCLES = 20;

  typedef logic signed [mse_pkg::DATA_W-1:0] word_t;

  typedef struct {
    word_t word;
    logic  tail;
  } sorted_beat_t;

  localparam word_t WORD_MIN = {1'b1, {(mse_pkg::DATA_W-1){1'b0}}};
  localparam word_t WORD_MAX = {1'b0, {(mse_pkg::DATA_W-1){1'b1}}};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  mse_in_if  in_ch ();
  mse_out_if out_ch ();

  merge_sort_engine #(
    .MAX_ELEMENTS(CAPACITY)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  // words of the set being loaded, and sorted beats still to arrive
  word_t        loaded_words[$];
  sorted_beat_t pending_sorted_q[$];

  int mismatch_count = 0;
  int beats_sent = 0;
  int beats_dropped = 0;
  int sets_closed = 0;
  int beats_checked = 0;

  // idling odds in percent: per input beat for gaps, per ready clock for stalls
  int send_gap_pct = 0;
  int stall_pct = 0;

  always #2 clk_i = ~clk_i;

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // full-range words mixed with extremes and a narrow band for ties
  function automatic word_t pick_word();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return word_t'($urandom);
      5, 6:          return word_t'($signed($urandom_range(0, 7)) - 4);
      7:             return WORD_MIN;
      8:             return WORD_MAX;
      default:       return ($urandom_range(0, 1) != 0) ? word_t'(-1) : word_t'(0);
    endcase
  endfunction

  // track one accepted beat; a closing beat sorts the set stably
  task automatic note_beat(input word_t value, input logic last);
    word_t        key;
    int           j;
    sorted_beat_t b;
    if (loaded_words.size() < CAPACITY) begin
      loaded_words.push_back(value);
    end else begin
      beats_dropped++;
    end
    if (last) begin
      // insertion sort, strict compare keeps the left word first on ties
      for (int i = 1; i < loaded_words.size(); i++) begin
        key = loaded_words[i];
        j = i - 1;
        while (j >= 0 && loaded_words[j] > key) begin
          loaded_words[j+1] = loaded_words[j];
          j--;
        end
        loaded_words[j+1] = key;
      end
      foreach (loaded_words[k]) begin
        b.word = loaded_words[k];
        b.tail = (k == loaded_words.size() - 1);
        pending_sorted_q.push_back(b);
      end
      loaded_words.delete();
      sets_closed++;
    end
  endtask

  // drive one input beat and wait for the handshake
  task automatic send_beat(input word_t value, input logic last);
    int gap;
    gap = ($urandom_range(0, 99) < send_gap_pct) ? pick_gap() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= value;
    in_ch.last  <= last;
    do @(posedge clk_i); while (!in_ch.ready);
    note_beat(value, last);
    beats_sent++;
  endtask

  // send a whole set, flagging its final beat
  task automatic send_set(input word_t words[$]);
    foreach (words[i]) send_beat(words[i], i == words.size() - 1);
  endtask

  task automatic test_single_element();
    send_set('{word_t'(0)});
    send_set('{WORD_MAX});
  endtask

  task automatic test_extremes_and_ties();
    send_set('{WORD_MAX, WORD_MIN, word_t'(-1), word_t'(0), word_t'(1), WORD_MIN, WORD_MAX,
               word_t'(0)});
    send_set('{word_t'(7), word_t'(7)});
  endtask

  task automatic test_presorted_orders();
    send_set('{word_t'(-3), word_t'(-1), word_t'(2), word_t'(5), word_t'(9)});
    send_set('{word_t'(9), word_t'(5), word_t'(2), word_t'(-1), word_t'(-3)});
  endtask

  // exactly full, closed on the last slot
  task automatic test_full_buffer();
    word_t words[$];
    repeat (CAPACITY) words.push_back(pick_word());
    send_set(words);
  endtask

  // beats past capacity are dropped, the dropped closing beat still closes
  task automatic test_overflow();
    word_t words[$];
    repeat (CAPACITY + 2) words.push_back(pick_word());
    send_set(words);
    words.delete();
    repeat (CAPACITY + 1) words.push_back(pick_word());
    send_set(words);
  endtask

  // random sets, mostly small, with idling mode changing per set
  task automatic test_random_sets();
    word_t words[$];
    int    start;
    int    size;
    int    pick;
    start = beats_sent;
    while (beats_sent - start < RANDOM_BEATS) begin
      pick = $urandom_range(0, 99);
      if (pick < 70)      size = $urandom_range(1, 8);
      else if (pick < 90) size = $urandom_range(9, 40);
      else if (pick < 96) size = $urandom_range(41, CAPACITY);
      else                size = $urandom_range(CAPACITY + 1, CAPACITY + 6);
      case ($urandom_range(0, 3))
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 30; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 30; end
        default: begin send_gap_pct = 25; stall_pct = 25; end
      endcase
      words.delete();
      repeat (size) words.push_back(pick_word());
      send_set(words);
    end
  endtask

  // receiver side back-pressure
  initial begin
    int stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 99) < stall_pct) stall_left = pick_gap();
      end
    end
  end

  // compare each sorted beat against the oldest prediction
  always @(posedge clk_i) begin
    sorted_beat_t exp_b;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_sorted_q.size() == 0) begin
        $display("%0t: unexpected sorted beat, expected none, got %0d last %0b",
                 $time, out_ch.sorted_value, out_ch.last_out);
        mismatch_count++;
      end else begin
        exp_b = pending_sorted_q.pop_front();
        beats_checked++;
        if (out_ch.sorted_value !== exp_b.word) begin
          $display("%0t: sorted_value mismatch, expected %0d, got %0d",
                   $time, exp_b.word, out_ch.sorted_value);
          mismatch_count++;
        end
        if (out_ch.last_out !== exp_b.tail) begin
          $display("%0t: last_out mismatch, expected %0b, got %0b",
                   $time, exp_b.tail, out_ch.last_out);
          mismatch_count++;
        end
      end
    end
  end

  // hard stop
  initial begin
    #4000000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.value <= '0;
    in_ch.last  <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed sets with light idling, then random sets
    send_gap_pct = 20;
    stall_pct = 20;
    test_single_element();
    test_extremes_and_ties();
    test_presorted_orders();
    test_full_buffer();
    test_overflow();
    test_random_sets();

    // let the last sets drain
    @(posedge clk_i);
    in_ch.valid <= 1'b0;
    while (pending_sorted_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("sorted %0d sets from %0d input beats, %0d beats dropped at capacity",
             sets_closed, beats_sent, beats_dropped);
    $display("checked %0d sorted output beats", beats_checked);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/mse_pkg.sv
rtl/core/mse_if.sv
rtl/core/mse_mem.sv
rtl/core/mse_sorter.sv
rtl/core/merge_sort_engine.sv
verif/merge_sort_engine_tb.sv
